// File: src/sprld_pkg.sv
// ----------------------------------------------------------------------------
// Sprite run-length decoder package
// Shared constants, parse phases and word types for the sprite decoder.
// ----------------------------------------------------------------------------
package sprld_pkg;

  // Pixel budget of one sprite
  localparam int SPRITE_PIXELS = 1024;
  // Width of a pixel count that can hold the full budget
  localparam int PIX_W  = $clog2(SPRITE_PIXELS + 1);
  // Width of the run_length field on the result port
  localparam int RUN_W  = 11;
  // Byte counters and the dump length
  localparam int LEN_W  = 16;
  // Compare widths: run clamp and colored-bytes-vs-remaining check
  localparam int WIDE_W = (PIX_W > LEN_W) ? PIX_W : LEN_W;
  localparam int CMP_W  = (((PIX_W + 2) > LEN_W) ? (PIX_W + 2) : LEN_W) + 1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Component index of the last byte of a pixel
  localparam logic [1:0] LAST_RGB  = 2'd2;
  localparam logic [1:0] LAST_RGBA = 2'd3;

  // Output queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_TLO = 5'b00001,  // transparent count, low byte
    PH_THI = 5'b00010,  // transparent count, high byte
    PH_CLO = 5'b00100,  // colored count, low byte
    PH_CHI = 5'b01000,  // colored count, high byte
    PH_PIX = 5'b10000   // colored pixel bytes
  } phase_t;

  // One input word
  typedef struct packed {
    logic             first_of_sprite;
    logic [LEN_W-1:0] dump_length;
    logic [7:0]       byte_value;
  } item_t;

  // One result word
  typedef struct packed {
    logic [RUN_W-1:0] run_length;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             end_of_sprite;
    logic             saw_visible_alpha;
    logic             saw_nonblack;
  } res_t;

endpackage

// File: src/sprite_run_length_decoder.sv
// ----------------------------------------------------------------------------
// Sprite run-length decoder
// Decodes a run-length sprite dump, one byte per word, into RGBA run words.
// ----------------------------------------------------------------------------
// Path: a result word passes the input register, then the output queue,
//   before it is offered.
// Throughput: one byte per cycle while the output queue has room for two
//   words (else in_stall is raised); a byte that yields two words (a run or
//   pixel plus the end word) is absorbed by the four-word output queue.
// Reset: synchronous, active low; clears parse state, queue and use_alpha.
module sprite_run_length_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_of_sprite,
  input  logic [15:0] in_dump_length,
  input  logic [7:0]  in_byte_value,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_run_length,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_end_of_sprite,
  output logic        out_saw_visible_alpha,
  output logic        out_saw_nonblack,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_use_alpha
);

  logic                          use_alpha_r;
  logic                          s1_valid_r, s1_valid_nxt;
  sprld_pkg::item_t              s1_item_r;
  logic                          s1_go;
  logic                          in_take;
  sprld_pkg::res_t               res0, res1, head;
  logic                          push0, push1;
  logic                          pop;
  logic                          q_not_empty;
  logic [sprld_pkg::Q_CNT_W-1:0] q_count;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_alpha_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      use_alpha_r <= cfg_use_alpha;
    end
  end

  // Input register: decode proceeds when the queue has room for two words
  assign s1_go    = s1_valid_r &&
                    (q_count <= sprld_pkg::Q_CNT_W'(sprld_pkg::Q_DEPTH - 2));
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.first_of_sprite <= in_first_of_sprite;
      s1_item_r.dump_length     <= in_dump_length;
      s1_item_r.byte_value      <= in_byte_value;
    end
  end

  // Decode
  sprld_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .item      (s1_item_r),
    .use_alpha (use_alpha_r),
    .res0      (res0),
    .push0     (push0),
    .res1      (res1),
    .push1     (push1)
  );

  // Result queue
  assign pop = q_not_empty && !out_stall;

  sprld_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res0      (res0),
    .push0     (push0),
    .res1      (res1),
    .push1     (push1),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign out_valid             = q_not_empty;
  assign out_run_length        = head.run_length;
  assign out_red               = head.red;
  assign out_green             = head.green;
  assign out_blue              = head.blue;
  assign out_alpha             = head.alpha;
  assign out_end_of_sprite     = head.end_of_sprite;
  assign out_saw_visible_alpha = head.saw_visible_alpha;
  assign out_saw_nonblack      = head.saw_nonblack;

`ifndef ASSERT_OFF
  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= sprld_pkg::Q_CNT_W'(sprld_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  // Words are only produced for a byte being decoded
  a_push_go: assert property (@(posedge clk) disable iff (!rst_n)
    (push0 || push1) |-> s1_go)
    else $error("result word without a byte in decode");

  // The second word is always the end word
  a_push1_end: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> res1.end_of_sprite)
    else $error("second word is not an end word");

  // A decoded byte leaves the input register unless refilled
  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !in_take) |=> !s1_valid_r)
    else $error("input register not drained");
`endif

endmodule

// File: src/sprld_core.sv
// ----------------------------------------------------------------------------
// Sprite decoder core
// Holds the parse state and turns one dump byte into at most two result
// words (a run or pixel word, then the end word) in the same cycle as go.
// ----------------------------------------------------------------------------
module sprld_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  sprld_pkg::item_t     item,
  input  logic                 use_alpha,
  output sprld_pkg::res_t      res0,
  output logic                 push0,
  output sprld_pkg::res_t      res1,
  output logic                 push1
);

  sprld_pkg::phase_t             phase_r, phase_nxt;
  logic [7:0]                    clo_r, clo_nxt;
  logic [sprld_pkg::PIX_W-1:0]   rr_r, rr_nxt;
  logic [sprld_pkg::PIX_W-1:0]   pw_r, pw_nxt;
  logic [sprld_pkg::LEN_W-1:0]   bc_r, bc_nxt;
  logic [sprld_pkg::LEN_W-1:0]   be_r, be_nxt;
  logic [1:0]                    ci_r, ci_nxt;
  logic [23:0]                   pp_r, pp_nxt;
  logic                          as_r, as_nxt;
  logic                          ns_r, ns_nxt;
  logic                          halted_r, halted_nxt;

  logic [sprld_pkg::LEN_W-1:0]   index;
  logic [sprld_pkg::LEN_W-1:0]   idx_p1;
  logic [sprld_pkg::LEN_W-1:0]   remaining;
  logic [sprld_pkg::PIX_W-1:0]   left;
  logic [sprld_pkg::PIX_W-1:0]   cnt;
  logic [sprld_pkg::LEN_W-1:0]   raw_cnt;
  logic [sprld_pkg::CMP_W-1:0]   need;
  logic [1:0]                    last_ci;
  logic [7:0]                    pr, pg, pb, pa;

  // Next-state and result words for the byte in flight
  always_comb begin
    phase_nxt  = phase_r;
    clo_nxt    = clo_r;
    rr_nxt     = rr_r;
    pw_nxt     = pw_r;
    bc_nxt     = bc_r;
    be_nxt     = be_r;
    ci_nxt     = ci_r;
    pp_nxt     = pp_r;
    as_nxt     = as_r;
    ns_nxt     = ns_r;
    halted_nxt = halted_r;
    res0       = '0;
    res1       = '0;
    push0      = 1'b0;
    push1      = 1'b0;
    index      = bc_r;
    idx_p1     = '0;
    remaining  = '0;
    left       = '0;
    cnt        = '0;
    raw_cnt    = '0;
    need       = '0;
    last_ci    = use_alpha ? sprld_pkg::LAST_RGBA : sprld_pkg::LAST_RGB;
    pr         = '0;
    pg         = '0;
    pb         = '0;
    pa         = '0;

    if (go) begin
      // restart on the first byte of a sprite
      if (item.first_of_sprite) begin
        phase_nxt  = sprld_pkg::PH_TLO;
        clo_nxt    = '0;
        rr_nxt     = '0;
        pw_nxt     = '0;
        bc_nxt     = '0;
        be_nxt     = item.dump_length;
        ci_nxt     = '0;
        pp_nxt     = '0;
        as_nxt     = 1'b0;
        ns_nxt     = 1'b0;
        halted_nxt = 1'b0;
        index      = '0;
      end

      if (item.first_of_sprite && (item.dump_length == '0)) begin
        // empty dump: one end word covering the whole sprite
        res1.run_length    = sprld_pkg::RUN_W'(sprld_pkg::SPRITE_PIXELS);
        res1.end_of_sprite = 1'b1;
        push1              = 1'b1;
        pw_nxt             = sprld_pkg::PIX_W'(sprld_pkg::SPRITE_PIXELS);
        halted_nxt         = 1'b1;
      end else if (index < be_nxt) begin
        idx_p1    = index + 1'b1;
        bc_nxt    = idx_p1;
        remaining = be_nxt - idx_p1;
        left      = sprld_pkg::PIX_W'(sprld_pkg::SPRITE_PIXELS) - pw_nxt;
        raw_cnt   = {item.byte_value, clo_nxt};
        // run clamped to the unwritten pixels
        if (sprld_pkg::WIDE_W'(raw_cnt) > sprld_pkg::WIDE_W'(left)) begin
          cnt = left;
        end else begin
          cnt = sprld_pkg::PIX_W'(raw_cnt);
        end
        need = use_alpha ? (sprld_pkg::CMP_W'(cnt) << 2)
                         : ((sprld_pkg::CMP_W'(cnt) << 1) + sprld_pkg::CMP_W'(cnt));

        if (!halted_nxt) begin
          unique case (phase_nxt)
            sprld_pkg::PH_TLO: begin
              clo_nxt   = item.byte_value;
              phase_nxt = sprld_pkg::PH_THI;
            end
            sprld_pkg::PH_THI: begin
              if (cnt != '0) begin
                res0.run_length = sprld_pkg::RUN_W'(cnt);
                push0           = 1'b1;
              end
              pw_nxt    = pw_nxt + cnt;
              phase_nxt = sprld_pkg::PH_CLO;
            end
            sprld_pkg::PH_CLO: begin
              clo_nxt   = item.byte_value;
              phase_nxt = sprld_pkg::PH_CHI;
            end
            sprld_pkg::PH_CHI: begin
              if (need > sprld_pkg::CMP_W'(remaining)) begin
                // colored bytes would pass the dump end: fill and stop
                if (left != '0) begin
                  res0.run_length = sprld_pkg::RUN_W'(left);
                  push0           = 1'b1;
                end
                pw_nxt     = sprld_pkg::PIX_W'(sprld_pkg::SPRITE_PIXELS);
                halted_nxt = 1'b1;
              end else if (cnt == '0) begin
                phase_nxt = sprld_pkg::PH_TLO;
              end else begin
                rr_nxt    = cnt;
                ci_nxt    = '0;
                phase_nxt = sprld_pkg::PH_PIX;
              end
            end
            sprld_pkg::PH_PIX: begin
              if (ci_nxt >= last_ci) begin
                // last byte of a pixel
                pr = pp_nxt[7:0];
                pg = pp_nxt[15:8];
                if (ci_nxt == sprld_pkg::LAST_RGBA) begin
                  pb = pp_nxt[23:16];
                  pa = use_alpha ? item.byte_value : sprld_pkg::ALPHA_OPAQUE;
                end else begin
                  pb = item.byte_value;
                  pa = sprld_pkg::ALPHA_OPAQUE;
                end
                if (pa != '0) begin
                  as_nxt = 1'b1;
                end
                if ((pr | pg | pb) != '0) begin
                  ns_nxt = 1'b1;
                end
                res0.run_length = sprld_pkg::RUN_W'(1);
                res0.red        = pr;
                res0.green      = pg;
                res0.blue       = pb;
                res0.alpha      = pa;
                push0           = 1'b1;
                pw_nxt          = pw_nxt + 1'b1;
                ci_nxt          = '0;
                pp_nxt          = '0;
                if (rr_nxt != '0) begin
                  rr_nxt = rr_nxt - 1'b1;
                end
                if (rr_nxt == '0) begin
                  phase_nxt = sprld_pkg::PH_TLO;
                end
              end else begin
                // gather a colour component
                unique case (ci_nxt)
                  2'd0:    pp_nxt[7:0]   = item.byte_value;
                  2'd1:    pp_nxt[15:8]  = item.byte_value;
                  2'd2:    pp_nxt[23:16] = item.byte_value;
                  default: pp_nxt        = pp_nxt;
                endcase
                ci_nxt = ci_nxt + 1'b1;
              end
            end
            default: phase_nxt = sprld_pkg::PH_TLO;
          endcase
          if (pw_nxt >= sprld_pkg::PIX_W'(sprld_pkg::SPRITE_PIXELS)) begin
            halted_nxt = 1'b1;
          end
        end

        // last dump byte: end word fills the rest
        if (idx_p1 == be_nxt) begin
          res1.run_length =
            sprld_pkg::RUN_W'(sprld_pkg::PIX_W'(sprld_pkg::SPRITE_PIXELS) - pw_nxt);
          res1.end_of_sprite     = 1'b1;
          res1.saw_visible_alpha = as_nxt;
          res1.saw_nonblack      = ns_nxt;
          push1                  = 1'b1;
          pw_nxt                 = sprld_pkg::PIX_W'(sprld_pkg::SPRITE_PIXELS);
          halted_nxt             = 1'b1;
        end
      end
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sprld_pkg::PH_TLO;
      clo_r    <= '0;
      rr_r     <= '0;
      pw_r     <= '0;
      bc_r     <= '0;
      be_r     <= '0;
      ci_r     <= '0;
      pp_r     <= '0;
      as_r     <= 1'b0;
      ns_r     <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      clo_r    <= clo_nxt;
      rr_r     <= rr_nxt;
      pw_r     <= pw_nxt;
      bc_r     <= bc_nxt;
      be_r     <= be_nxt;
      ci_r     <= ci_nxt;
      pp_r     <= pp_nxt;
      as_r     <= as_nxt;
      ns_r     <= ns_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// File: src/sprld_outq.sv
// ----------------------------------------------------------------------------
// Sprite decoder output queue
// Small result queue taking up to two words per cycle, giving one per cycle while popped.
// ----------------------------------------------------------------------------
module sprld_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sprld_pkg::res_t                res0,
  input  logic                           push0,
  input  sprld_pkg::res_t                res1,
  input  logic                           push1,
  input  logic                           pop,
  output sprld_pkg::res_t                head,
  output logic                           not_empty,
  output logic [sprld_pkg::Q_CNT_W-1:0]  count
);

  sprld_pkg::res_t                 mem_r [sprld_pkg::Q_DEPTH];
  logic [sprld_pkg::Q_PTR_W-1:0]   head_r, head_nxt;
  logic [sprld_pkg::Q_PTR_W-1:0]   tail_r, tail_nxt;
  logic [sprld_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic [sprld_pkg::Q_PTR_W-1:0]   tail_p1;
  sprld_pkg::res_t                 wr_a;
  logic [1:0]                      n_push;

  // Compact the pushed words: res1 alone goes to the tail slot
  always_comb begin
    tail_p1   = tail_r + 1'b1;
    wr_a      = push0 ? res0 : res1;
    n_push    = {1'b0, push0} + {1'b0, push1};
    head_nxt  = pop ? (head_r + 1'b1) : head_r;
    tail_nxt  = tail_r + sprld_pkg::Q_PTR_W'(n_push);
    count_nxt = count_r + sprld_pkg::Q_CNT_W'(n_push) - sprld_pkg::Q_CNT_W'(pop);
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push0 || push1) begin
      mem_r[tail_r] <= wr_a;
    end
    if (push0 && push1) begin
      mem_r[tail_p1] <= res1;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign head      = mem_r[head_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule
